>>> sv/lens_undistortion_map_macros.svh
// ----------------------------------------------------------------------------
// lens undistortion map assertion macros
// concurrent assertion wrappers, empty in synthesis
// ----------------------------------------------------------------------------
`ifndef LENS_UNDISTORTION_MAP_MACROS_SVH
`define LENS_UNDISTORTION_MAP_MACROS_SVH

`ifndef SYNTHESIS
`define LUM_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);
`define LUM_ASSERT_RST(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) prop) else $error(msg);
`else
`define LUM_ASSERT(lbl, prop, msg)
`define LUM_ASSERT_RST(lbl, prop, msg)
`endif

`endif

>>> sv/lum_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lens undistortion map package
// register codes, field widths and defaults
// ----------------------------------------------------------------------------
package lum_pkg;

  localparam int DEF_MAX_COLS = 4096;
  localparam int DEF_MAX_ROWS = 4096;
  localparam int LANES        = 2;
  localparam int CRD_W        = 12;
  localparam int CFG_W        = 32;
  localparam int CFG_IDX_W    = 3;
  localparam int CTR_W        = 20;
  localparam int MAP_W        = 22;
  localparam int DIV_BITS     = 23;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_INV_FOCAL_X   = 3'd0,
    REG_NORM_OFFSET_X = 3'd1,
    REG_INV_FOCAL_Y   = 3'd2,
    REG_NORM_OFFSET_Y = 3'd3,
    REG_CENTER_U      = 3'd4,
    REG_CENTER_V      = 3'd5,
    REG_RADIAL_K1     = 3'd6,
    REG_RADIAL_K2     = 3'd7
  } cfg_reg_t;

endpackage

>>> sv/lens_undistortion_map.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lens undistortion map
// division-model source coordinate generator, when not stalled one pixel per clock
// ----------------------------------------------------------------------------
// usage:
//   input channel carries a destination pixel (column, row) with in_valid and
//   in_stall; result channel carries map_x, map_y (signed Q13.8) and
//   out_of_range with out_valid and out_stall
//   configuration registers must be written (the block does not enforce this)
//   through cfg_we / cfg_idx / cfg_wdata while no pixel is in flight
//   from input transfer to out_valid the pipeline has ten arithmetic
//   stages, 23 restoring divider stages (one quotient bit each) and the
//   output register
//   throughput is one pixel per cycle while out_stall does not hold the
//   pipeline, set by the fully pipelined multipliers and divider stages
//   a synchronous reset clears all valid bits and the configuration registers
//   while out_valid is high and out_stall is high the whole pipeline holds
//   and in_stall is raised, no transfer is lost or repeated
`include "lens_undistortion_map_macros.svh"
module lens_undistortion_map
  import lum_pkg::*;
#(
  parameter int MAX_COLS = DEF_MAX_COLS,
  parameter int MAX_ROWS = DEF_MAX_ROWS
) (
  input  logic                    clk,
  input  logic                    rst_n,
  input  logic                    cfg_we,
  input  logic [CFG_IDX_W-1:0]    cfg_idx,
  input  logic [CFG_W-1:0]        cfg_wdata,
  input  logic                    in_valid,
  output logic                    in_stall,
  input  logic [CRD_W-1:0]        in_pixel_col,
  input  logic [CRD_W-1:0]        in_pixel_row,
  output logic                    out_valid,
  input  logic                    out_stall,
  output logic signed [MAP_W-1:0] out_map_x,
  output logic signed [MAP_W-1:0] out_map_y,
  output logic                    out_out_of_range
);

  localparam int NSTG   = 11 + DIV_BITS;
  localparam int DV0    = 9;
  localparam int DVN    = DV0 + DIV_BITS;

  // configuration
  logic        [31:0]      inv_r [0:LANES-1];
  logic signed [31:0]      off_r [0:LANES-1];
  logic        [CTR_W-1:0] ctr_r [0:LANES-1];
  logic signed [31:0]      k1_r, k2_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int l = 0; l < LANES; l++) begin
        inv_r[l] <= '0;
        off_r[l] <= '0;
        ctr_r[l] <= '0;
      end
      k1_r <= '0;
      k2_r <= '0;
    end else if (cfg_we) begin
      case (cfg_reg_t'(cfg_idx))
        REG_INV_FOCAL_X:   inv_r[0] <= cfg_wdata;
        REG_NORM_OFFSET_X: off_r[0] <= cfg_wdata;
        REG_INV_FOCAL_Y:   inv_r[1] <= cfg_wdata;
        REG_NORM_OFFSET_Y: off_r[1] <= cfg_wdata;
        REG_CENTER_U:      ctr_r[0] <= cfg_wdata[CTR_W-1:0];
        REG_CENTER_V:      ctr_r[1] <= cfg_wdata[CTR_W-1:0];
        REG_RADIAL_K1:     k1_r     <= cfg_wdata;
        REG_RADIAL_K2:     k2_r     <= cfg_wdata;
        default: ;
      endcase
    end
  end

  // pipeline control
  logic [NSTG-1:0] vld_r;
  logic            adv;

  assign adv       = !vld_r[NSTG-1] || !out_stall;
  assign in_stall  = !adv;
  assign out_valid = vld_r[NSTG-1];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= '0;
    end else if (adv) begin
      vld_r <= {vld_r[NSTG-2:0], in_valid};
    end
  end

  // stage registers
  logic        [43:0]      prod1_r [0:LANES-1];
  logic        [CRD_W-1:0] crd1_r  [0:LANES-1];
  logic signed [31:0]      nrm2_r  [0:LANES-1];
  logic        [CRD_W-1:0] crd2_r  [0:LANES-1];
  logic                    flg2_r;
  logic        [63:0]      sq3_r   [0:LANES-1];
  logic        [CRD_W-1:0] crd3_r  [0:LANES-1];
  logic                    flg3_r;
  logic        [31:0]      r2_4_r;
  logic        [CRD_W-1:0] crd4_r  [0:LANES-1];
  logic                    flg4_r;
  logic        [63:0]      r4p5_r;
  logic signed [63:0]      k1p5_r;
  logic        [CRD_W-1:0] crd5_r  [0:LANES-1];
  logic                    flg5_r;
  logic        [31:0]      r4_6_r;
  logic signed [39:0]      t1_6_r;
  logic        [CRD_W-1:0] crd6_r  [0:LANES-1];
  logic                    flg6_r;
  logic signed [63:0]      k2p7_r;
  logic signed [39:0]      t1_7_r;
  logic        [CRD_W-1:0] crd7_r  [0:LANES-1];
  logic                    flg7_r;
  logic signed [41:0]      fac8_r;
  logic        [CRD_W-1:0] crd8_r  [0:LANES-1];
  logic                    flg8_r;
  logic        [CTR_W-1:0] mag9_r  [0:LANES-1];
  logic                    neg9_r  [0:LANES-1];
  logic signed [41:0]      fac9_r;
  logic                    flg9_r;

  // divider pipe, index 0 is its entry
  logic [40:0]         dp_r   [0:DIV_BITS][0:LANES-1];
  logic [DIV_BITS-1:0] dn_r   [0:DIV_BITS][0:LANES-1];
  logic [DIV_BITS-1:0] dq_r   [0:DIV_BITS][0:LANES-1];
  logic                dneg_r [0:DIV_BITS][0:LANES-1];
  logic                dovf_r [0:DIV_BITS][0:LANES-1];
  logic [40:0]         df_r   [0:DIV_BITS];
  logic                dfpos_r[0:DIV_BITS];
  logic                dflg_r [0:DIV_BITS];

  logic signed [MAP_W-1:0] map_r [0:LANES-1];
  logic                    oor_r;

  // next values
  logic        [CRD_W-1:0] crd0     [0:LANES-1];
  logic signed [31:0]      nrm2_nxt [0:LANES-1];
  logic                    flg2_nxt;
  logic        [63:0]      sq3_nxt  [0:LANES-1];
  logic        [31:0]      r2_4_nxt;
  logic                    flg4_nxt;
  logic signed [64:0]      k1p5_nxt;
  logic        [31:0]      r4_6_nxt;
  logic                    flg6_nxt;
  logic signed [64:0]      k2p7_nxt;
  logic signed [41:0]      fac8_nxt;
  logic        [CTR_W-1:0] mag9_nxt [0:LANES-1];
  logic                    neg9_nxt [0:LANES-1];
  logic [40:0]             dp0_nxt  [0:LANES-1];
  logic [DIV_BITS-1:0]     dn0_nxt  [0:LANES-1];
  logic                    dovf0_nxt[0:LANES-1];
  logic signed [MAP_W-1:0] map_nxt  [0:LANES-1];
  logic                    oor_nxt;

  always_comb begin
    logic signed [37:0]      sum2;
    logic        [31:0]      mag3;
    logic        [64:0]      sum4;
    logic signed [20:0]      d9;
    logic        [48:0]      num;
    logic signed [24:0]      res;
    logic        [40:0]      fdiv;
    // clamp
    crd0[0] = (int'(in_pixel_col) >= MAX_COLS) ? CRD_W'(MAX_COLS - 1) : in_pixel_col;
    crd0[1] = (int'(in_pixel_row) >= MAX_ROWS) ? CRD_W'(MAX_ROWS - 1) : in_pixel_row;
    // normalize with saturation
    flg2_nxt = 1'b0;
    for (int l = 0; l < LANES; l++) begin
      sum2 = $signed({2'b00, prod1_r[l][43:8]}) + {{6{off_r[l][31]}}, off_r[l]};
      if (sum2 > 38'sd2147483647) begin
        nrm2_nxt[l] = 32'sh7fffffff;
        flg2_nxt    = 1'b1;
      end else if (sum2 < -38'sd2147483648) begin
        nrm2_nxt[l] = 32'sh80000000;
        flg2_nxt    = 1'b1;
      end else begin
        nrm2_nxt[l] = sum2[31:0];
      end
    end
    // squares
    for (int l = 0; l < LANES; l++) begin
      mag3       = nrm2_r[l][31] ? 32'(-nrm2_r[l]) : nrm2_r[l];
      sq3_nxt[l] = 64'(mag3) * 64'(mag3);
    end
    // r2
    sum4     = {1'b0, sq3_r[0]} + {1'b0, sq3_r[1]};
    flg4_nxt = flg3_r | (|sum4[64:56]);
    r2_4_nxt = (|sum4[64:56]) ? 32'hffffffff : sum4[55:24];
    k1p5_nxt = 65'(k1_r) * $signed({33'b0, r2_4_r});
    // r4
    flg6_nxt = flg5_r | (|r4p5_r[63:56]);
    r4_6_nxt = (|r4p5_r[63:56]) ? 32'hffffffff : r4p5_r[55:24];
    k2p7_nxt = 65'(k2_r) * $signed({33'b0, r4_6_r});
    // factor, Q.28
    fac8_nxt = 42'sd268435456 + {{2{t1_7_r[39]}}, t1_7_r}
             + {{2{k2p7_r[63]}}, k2p7_r[63:24]};
    // offset from center
    for (int l = 0; l < LANES; l++) begin
      d9          = $signed({1'b0, crd8_r[l], 8'b0}) - $signed({1'b0, ctr_r[l]});
      neg9_nxt[l] = d9[20];
      mag9_nxt[l] = d9[20] ? CTR_W'(-d9) : d9[CTR_W-1:0];
    end
    // dividend with rounding term, overflow when quotient needs more bits
    fdiv = fac9_r[40:0];
    for (int l = 0; l < LANES; l++) begin
      num           = {1'b0, mag9_r[l], 28'b0} + 49'(fdiv >> 1);
      dovf0_nxt[l]  = {15'b0, num[48:DIV_BITS]} >= fdiv;
      dp0_nxt[l]    = 41'(num[48:DIV_BITS]);
      dn0_nxt[l]    = num[DIV_BITS-1:0];
    end
    // final add and saturation
    oor_nxt = dflg_r[DIV_BITS] | !dfpos_r[DIV_BITS];
    for (int l = 0; l < LANES; l++) begin
      res = dneg_r[DIV_BITS][l]
          ? $signed({5'b0, ctr_r[l]}) - $signed({2'b0, dq_r[DIV_BITS][l]})
          : $signed({5'b0, ctr_r[l]}) + $signed({2'b0, dq_r[DIV_BITS][l]});
      if (!dfpos_r[DIV_BITS]) begin
        map_nxt[l] = '0;
      end else if (dovf_r[DIV_BITS][l] || res > 25'sd2097151 || res < -25'sd2097152) begin
        oor_nxt    = 1'b1;
        map_nxt[l] = dneg_r[DIV_BITS][l] ? -22'sd2097152 : 22'sd2097151;
      end else begin
        map_nxt[l] = res[MAP_W-1:0];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      for (int l = 0; l < LANES; l++) begin
        prod1_r[l]      <= 44'(inv_r[l]) * 44'(crd0[l]);
        crd1_r[l]       <= crd0[l];
        nrm2_r[l]       <= nrm2_nxt[l];
        crd2_r[l]       <= crd1_r[l];
        sq3_r[l]        <= sq3_nxt[l];
        crd3_r[l]       <= crd2_r[l];
        crd4_r[l]       <= crd3_r[l];
        crd5_r[l]       <= crd4_r[l];
        crd6_r[l]       <= crd5_r[l];
        crd7_r[l]       <= crd6_r[l];
        crd8_r[l]       <= crd7_r[l];
        mag9_r[l]       <= mag9_nxt[l];
        neg9_r[l]       <= neg9_nxt[l];
        dp_r[0][l]      <= dp0_nxt[l];
        dn_r[0][l]      <= dn0_nxt[l];
        dq_r[0][l]      <= '0;
        dneg_r[0][l]    <= neg9_r[l];
        dovf_r[0][l]    <= dovf0_nxt[l];
        map_r[l]        <= map_nxt[l];
      end
      flg2_r     <= flg2_nxt;
      flg3_r     <= flg2_r;
      r2_4_r     <= r2_4_nxt;
      flg4_r     <= flg4_nxt;
      r4p5_r     <= 64'(r2_4_r) * 64'(r2_4_r);
      k1p5_r     <= k1p5_nxt[63:0];
      flg5_r     <= flg4_r;
      r4_6_r     <= r4_6_nxt;
      t1_6_r     <= k1p5_r[63:24];
      flg6_r     <= flg6_nxt;
      k2p7_r     <= k2p7_nxt[63:0];
      t1_7_r     <= t1_6_r;
      flg7_r     <= flg6_r;
      fac8_r     <= fac8_nxt;
      flg8_r     <= flg7_r;
      fac9_r     <= fac8_r;
      flg9_r     <= flg8_r;
      df_r[0]    <= fac9_r[40:0];
      dfpos_r[0] <= fac9_r > 42'sd0;
      dflg_r[0]  <= flg9_r;
      oor_r      <= oor_nxt;
    end
  end

  // restoring divider, one quotient bit per stage
  for (genvar k = 0; k < DIV_BITS; k++) begin : g_div
    logic [41:0] pp  [0:LANES-1];
    logic        ge  [0:LANES-1];
    logic [41:0] dif [0:LANES-1];

    always_comb begin
      for (int l = 0; l < LANES; l++) begin
        pp[l]  = {dp_r[k][l], dn_r[k][l][DIV_BITS-1]};
        dif[l] = pp[l] - {1'b0, df_r[k]};
        ge[l]  = pp[l] >= {1'b0, df_r[k]};
      end
    end

    always_ff @(posedge clk) begin
      if (adv) begin
        for (int l = 0; l < LANES; l++) begin
          dp_r[k+1][l]   <= ge[l] ? dif[l][40:0] : pp[l][40:0];
          dn_r[k+1][l]   <= {dn_r[k][l][DIV_BITS-2:0], 1'b0};
          dq_r[k+1][l]   <= {dq_r[k][l][DIV_BITS-2:0], ge[l]};
          dneg_r[k+1][l] <= dneg_r[k][l];
          dovf_r[k+1][l] <= dovf_r[k][l];
        end
        df_r[k+1]    <= df_r[k];
        dfpos_r[k+1] <= dfpos_r[k];
        dflg_r[k+1]  <= dflg_r[k];
      end
    end
  end

  assign out_map_x        = map_r[0];
  assign out_map_y        = map_r[1];
  assign out_out_of_range = oor_r;

  `LUM_ASSERT_RST(a_reset_clears, $past(!rst_n) |-> (vld_r == '0), "valid bits after reset")
  `LUM_ASSERT(a_hold_on_stall, (out_valid && out_stall) |=> $stable(vld_r), "pipe moved on stall")
  `LUM_ASSERT(a_entry, (in_valid && !in_stall) |=> vld_r[0], "transfer not captured")
  `LUM_ASSERT(a_div_rem, (vld_r[DVN] && dfpos_r[DIV_BITS] && !dovf_r[DIV_BITS][0]) |-> (dp_r[DIV_BITS][0] < df_r[DIV_BITS]), "remainder bound")

endmodule
